// ----- rtl/pid_pkg.sv -----
// Shared widths, constants, register indexes and rounding helper for the PID controller step.
package pid_pkg;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   // Integral clamp, 300.0 in Q16.16.
   localparam logic signed [31:0] INTEGRAL_LIMIT = 32'sd19660800;
   localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

   // floor(ms / 125) = (ms * RECIP_125) >> 39, exact for any 32-bit ms.
   localparam logic signed [33:0] RECIP_125 = 34'sd4398046512;
   localparam int RECIP_125_SHIFT = 39;
   // floor(b * 8192 / 125) = (b * FRAC_RECIP) >> 14, exact for b below 125.
   localparam logic signed [33:0] FRAC_RECIP = 34'sd1073742;

   // The quotient of the derivative divider has this many bits.
   localparam int DIV_STEPS = 33;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_TARGET       = 3'd0,
      CFG_GAIN_P       = 3'd1,
      CFG_GAIN_I       = 3'd2,
      CFG_GAIN_D       = 3'd3,
      CFG_OUTPUT_SCALE = 3'd4
   } cfg_index_type;

   // Q16.16 product scaled back by 2^16, rounded toward zero.
   function automatic logic signed [48:0] qtrunc(input logic signed [67:0] p);
      logic signed [67:0] t;
      t = p + (p[67] ? 68'sd65535 : 68'sd0);
      return t[64:16];
   endfunction

endpackage

// ----- rtl/pid_controller_step.sv -----
// PID controller step with clamped integral, built round one shared multiplier and a sequencer.
//
//   Channel  Direction  Handshake               Contents
//   req      in         req_tvalid/req_tready   measured_value, now_ms
//   rsp      out        rsp_tvalid/rsp_tready   drive, saturated flag
//   csr      in         csr_we                  target, gains, output scale
//
// A request holds the block from acceptance until its result enters the output register. When
// time has elapsed and the derivative quotient fits, the path includes the 33 steps of the
// bit-serial divider. With no elapsed time the divider and the derivative product are skipped;
// with a quotient known to overflow only the divider is skipped. Many of the other steps are
// one pass through the shared 34 x 34 bit multiplier.
// Reset is synchronous and active high; it restores the registers and clears the state.
// The block accepts a new request while the previous result still waits on rsp; it holds its
// final step, and is not ready, until the output register is free.
module pid_controller_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // From bit 0: measured_value [31:0], now_ms [63:32].
   input  logic [pid_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // From bit 0: drive [31:0].
   output logic [pid_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // From bit 0: saturated [0].
   output logic [pid_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                csr_we,
   input  logic [pid_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pid_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pid_pkg::*;

   // Sequencer steps. Many issue one multiplication whose product is consumed by the next.
   typedef enum logic [4:0] {
      S_IDLE,
      S_RECIP,
      S_QUO,
      S_REM,
      S_DT,
      S_INT_LO,
      S_INT_HI,
      S_INT_ACC,
      S_P,
      S_I,
      S_DIV,
      S_QSAT,
      S_D_MUL,
      S_D_ACC,
      S_SCALE,
      S_SC_HI,
      S_SC_LO,
      S_SC_SUM,
      S_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic signed [31:0] target_ff;
   logic signed [31:0] gain_p_ff;
   logic signed [31:0] gain_i_ff;
   logic signed [31:0] gain_d_ff;
   logic signed [31:0] scale_ff;

   // Controller state kept between requests.
   logic signed [31:0] integral_ff;
   logic signed [31:0] last_error_ff;
   logic [31:0]        last_time_ff;

   // Working registers for the request in flight.
   logic signed [31:0] err_ff;
   logic [31:0]        emag_ff;
   logic [31:0]        ms_ff;
   logic [25:0]        quo_ff;
   logic [38:0]        dt_ff;
   logic               dneg_ff;
   logic [31:0]        dmag_ff;
   logic [47:0]        ilo_ff;
   logic signed [48:0] sum_ff;
   logic [38:0]        rem_ff;
   logic [32:0]        shreg_ff;
   logic [5:0]         div_cnt_ff;
   logic               qover_ff;
   logic signed [31:0] satq_ff;
   logic               neg_ff;
   logic [47:0]        smag_ff;
   logic [31:0]        kmag_ff;
   logic               hk_big_ff;
   logic [38:0]        hk_ff;
   logic [47:0]        mag_ff;

   // Shared multiplier: operands chosen by the current step, product registered.
   logic signed [33:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [67:0] prod_ff;

   // Output register.
   logic               rsp_tvalid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_sat_ff;

   // Next values and helpers.
   logic               req_fire;
   logic signed [31:0] meas;
   logic [31:0]        now;
   logic signed [32:0] err_wide;
   logic signed [31:0] err_in;
   logic [31:0]        ms_in;
   logic signed [32:0] derr;
   logic [32:0]        dmag_wide;
   logic [32:0]        emag_wide;
   logic [32:0]        quo_x125;
   logic [32:0]        ms_rem;
   logic [49:0]        inc;
   logic signed [49:0] acc;
   logic signed [49:0] lim_pos;
   logic signed [49:0] lim_neg;
   logic signed [31:0] integral_in;
   logic [39:0]        rem_shift;
   logic               rem_ge;
   logic signed [31:0] satq_in;
   logic signed [48:0] sum_neg;
   logic signed [32:0] scale_neg;
   logic [47:0]        mag_in;
   logic [31:0]        drive_in;
   logic               sat_in;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign meas       = req_tdata[31:0];
   assign now        = req_tdata[63:32];

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // The error is saturated to 32 bits before any use.
   always_comb begin
      err_wide = {target_ff[31], target_ff} - {meas[31], meas};
      if (err_wide > 33'sd2147483647) begin
         err_in = S32_MAX;
      end else if (err_wide < -33'sd2147483648) begin
         err_in = S32_MIN;
      end else begin
         err_in = err_wide[31:0];
      end
      // A stored timestamp of zero means there was no previous sample.
      ms_in = (last_time_ff == 32'd0) ? 32'd0 : (now - last_time_ff);
   end

   always_comb begin
      derr      = {err_ff[31], err_ff} - {last_error_ff[31], last_error_ff};
      dmag_wide = derr[32] ? -derr : derr;
      emag_wide = err_ff[31] ? -{err_ff[31], err_ff} : {err_ff[31], err_ff};
      // ms minus 125 times its quotient, formed with shifts.
      quo_x125  = ({7'd0, quo_ff} << 7) - ({7'd0, quo_ff} << 1) - {7'd0, quo_ff};
      ms_rem    = {1'b0, ms_ff} - quo_x125;
   end

   // Integral update: the high-part product tells early whether the step is beyond the clamp.
   always_comb begin
      lim_pos = {{18{INTEGRAL_LIMIT[31]}}, INTEGRAL_LIMIT};
      lim_neg = -lim_pos;
      inc = {2'b00, ilo_ff} + {18'd0, prod_ff[15:0], 16'd0};
      acc = {{18{integral_ff[31]}}, integral_ff} + (err_ff[31] ? -$signed(inc) : $signed(inc));
      if (prod_ff[67:16] != 52'd0) begin
         integral_in = err_ff[31] ? -INTEGRAL_LIMIT : INTEGRAL_LIMIT;
      end else if (acc > lim_pos) begin
         integral_in = INTEGRAL_LIMIT;
      end else if (acc < lim_neg) begin
         integral_in = -INTEGRAL_LIMIT;
      end else begin
         integral_in = acc[31:0];
      end
   end

   // One restoring step of the derivative divider.
   always_comb begin
      rem_shift = {rem_ff, shreg_ff[32]};
      rem_ge    = (rem_shift >= {1'b0, dt_ff});
   end

   // The quotient is saturated to 32 bits before it meets gain_d.
   always_comb begin
      if (qover_ff) begin
         satq_in = dneg_ff ? S32_MIN : S32_MAX;
      end else if (dneg_ff) begin
         satq_in = (shreg_ff > 33'h0_8000_0000) ? S32_MIN : -shreg_ff[31:0];
      end else begin
         satq_in = (shreg_ff > 33'h0_7FFF_FFFF) ? S32_MAX : shreg_ff[31:0];
      end
   end

   always_comb begin
      sum_neg   = -sum_ff;
      scale_neg = -{scale_ff[31], scale_ff};
      // A high partial product at or above 2^39 puts the result far beyond the 32-bit range.
      mag_in    = hk_big_ff ? 48'h0100_0000_0000 : ({hk_ff, 8'd0} + {9'd0, prod_ff[54:16]});
      if (neg_ff) begin
         sat_in   = (mag_ff > 48'h0000_8000_0000);
         drive_in = sat_in ? S32_MIN : -mag_ff[31:0];
      end else begin
         sat_in   = (mag_ff > 48'h0000_7FFF_FFFF);
         drive_in = sat_in ? S32_MAX : mag_ff[31:0];
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = 34'sd0;
      mul_b = 34'sd0;
      case (state_ff)
         S_RECIP: begin
            mul_a = {2'b00, ms_ff};
            mul_b = RECIP_125;
         end
         S_REM: begin
            mul_a = {27'd0, ms_rem[6:0]};
            mul_b = FRAC_RECIP;
         end
         S_INT_LO: begin
            mul_a = {2'b00, emag_ff};
            mul_b = {2'b00, dt_ff[31:0]};
         end
         S_INT_HI: begin
            mul_a = {2'b00, emag_ff};
            mul_b = {27'd0, dt_ff[38:32]};
         end
         S_INT_ACC: begin
            mul_a = {{2{err_ff[31]}}, err_ff};
            mul_b = {{2{gain_p_ff[31]}}, gain_p_ff};
         end
         S_P: begin
            mul_a = {{2{integral_ff[31]}}, integral_ff};
            mul_b = {{2{gain_i_ff[31]}}, gain_i_ff};
         end
         S_D_MUL: begin
            mul_a = {{2{satq_ff[31]}}, satq_ff};
            mul_b = {{2{gain_d_ff[31]}}, gain_d_ff};
         end
         S_SC_HI: begin
            mul_a = {10'd0, smag_ff[47:24]};
            mul_b = {2'b00, kmag_ff};
         end
         S_SC_LO: begin
            mul_a = {10'd0, smag_ff[23:0]};
            mul_b = {2'b00, kmag_ff};
         end
         default: begin
            mul_a = 34'sd0;
            mul_b = 34'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;

      if (reset) begin
         state_ff      <= S_IDLE;
         target_ff     <= 32'sd0;
         gain_p_ff     <= 32'sd0;
         gain_i_ff     <= 32'sd0;
         gain_d_ff     <= 32'sd0;
         scale_ff      <= SCALE_RESET;
         integral_ff   <= 32'sd0;
         last_error_ff <= 32'sd0;
         last_time_ff  <= 32'd0;
         rsp_tvalid_ff <= 1'b0;
         div_cnt_ff    <= 6'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CFG_TARGET:       target_ff <= csr_wdata;
               CFG_GAIN_P:       gain_p_ff <= csr_wdata;
               CFG_GAIN_I:       gain_i_ff <= csr_wdata;
               CFG_GAIN_D:       gain_d_ff <= csr_wdata;
               CFG_OUTPUT_SCALE: scale_ff  <= csr_wdata;
               default:          ;
            endcase
         end

         // In the final step a taken result is replaced by the new one below.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  err_ff       <= err_in;
                  ms_ff        <= ms_in;
                  last_time_ff <= now;
                  state_ff     <= S_RECIP;
               end
            end
            S_RECIP: begin
               dneg_ff       <= derr[32];
               dmag_ff       <= dmag_wide[31:0];
               emag_ff       <= emag_wide[31:0];
               last_error_ff <= err_ff;
               state_ff      <= S_QUO;
            end
            S_QUO: begin
               quo_ff   <= prod_ff[64:RECIP_125_SHIFT];
               state_ff <= S_REM;
            end
            S_REM: begin
               state_ff <= S_DT;
            end
            S_DT: begin
               // Elapsed seconds: whole multiples of 125 ms, then the fraction from the rest.
               dt_ff    <= {quo_ff, prod_ff[26:14]};
               state_ff <= S_INT_LO;
            end
            S_INT_LO: begin
               state_ff <= S_INT_HI;
            end
            S_INT_HI: begin
               ilo_ff   <= prod_ff[63:16];
               state_ff <= S_INT_ACC;
            end
            S_INT_ACC: begin
               integral_ff <= integral_in;
               state_ff    <= S_P;
            end
            S_P: begin
               sum_ff   <= qtrunc(prod_ff);
               state_ff <= S_I;
            end
            S_I: begin
               sum_ff <= sum_ff + qtrunc(prod_ff);
               if (dt_ff == 39'd0) begin
                  state_ff <= S_SCALE;
               end else if ({24'd0, dmag_ff[31:17]} >= dt_ff) begin
                  // The numerator's top bits already reach the divisor: quotient at least 2^33.
                  qover_ff <= 1'b1;
                  state_ff <= S_QSAT;
               end else begin
                  qover_ff   <= 1'b0;
                  rem_ff     <= {24'd0, dmag_ff[31:17]};
                  shreg_ff   <= {dmag_ff[16:0], 16'd0};
                  div_cnt_ff <= 6'd0;
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff     <= rem_ge ? (rem_shift[38:0] - dt_ff) : rem_shift[38:0];
               shreg_ff   <= {shreg_ff[31:0], rem_ge};
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
                  state_ff <= S_QSAT;
               end
            end
            S_QSAT: begin
               satq_ff  <= satq_in;
               state_ff <= S_D_MUL;
            end
            S_D_MUL: begin
               state_ff <= S_D_ACC;
            end
            S_D_ACC: begin
               sum_ff   <= sum_ff + qtrunc(prod_ff);
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               neg_ff   <= sum_ff[48] ^ scale_ff[31];
               smag_ff  <= sum_ff[48] ? sum_neg[47:0] : sum_ff[47:0];
               kmag_ff  <= scale_ff[31] ? scale_neg[31:0] : scale_ff;
               state_ff <= S_SC_HI;
            end
            S_SC_HI: begin
               state_ff <= S_SC_LO;
            end
            S_SC_LO: begin
               hk_big_ff <= (prod_ff[67:39] != 29'd0);
               hk_ff     <= prod_ff[38:0];
               state_ff  <= S_SC_SUM;
            end
            S_SC_SUM: begin
               mag_ff   <= mag_in;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_data_ff   <= drive_in;
                  rsp_sat_ff    <= sat_in;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      (integral_ff <= INTEGRAL_LIMIT) && (integral_ff >= -INTEGRAL_LIMIT))
      else $error("integral left its clamp range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while the previous one was still in work");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < dt_ff))
      else $error("divider remainder not below the elapsed time");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000))
      else $error("saturation flagged on a drive that is not at a limit");
`endif

endmodule

// ----- tb/tb_pid_controller_step.sv -----
// Self-checking testbench for the PID controller step: directed corner cases, random runs, stalls.
module tb_pid_controller_step;
   import pid_pkg::*;

   // A run of this length is far beyond the slowest correct run, so reaching it means a hang.
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned IDLE_PERCENT = 13;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int RANDOM_PHASES = 9;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int FULL_RATE_ITEMS = 60;
   localparam int BURST_ITEMS = 10;

   // Q16.16 constants of the controller: 1.0 and the integral clamp of 300.0.
   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam longint INTEG_CLAMP = 64'sd19660800;

   typedef struct packed {
      logic [31:0] drive;
      logic        saturated;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pid_controller_step u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // From bit 0: measured_value [31:0], now_ms [63:32].
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // From bit 0: drive [31:0].
      .rsp_tuser  (rsp_tuser),   // From bit 0: saturated [0].
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the controller: its settings and its running state, at reset values.
   logic signed [31:0] set_target = 32'sd0;
   logic signed [31:0] set_gain_p = 32'sd0;
   logic signed [31:0] set_gain_i = 32'sd0;
   logic signed [31:0] set_gain_d = 32'sd0;
   logic signed [31:0] set_scale = Q_ONE;
   logic signed [31:0] integ_q = 32'sd0;
   logic signed [31:0] prev_error = 32'sd0;
   logic [31:0] prev_time_ms = 32'd0;

   // Drives predicted for accepted requests, oldest first.
   drive_result_type expected_drives[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit no_idle = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned stall_left = 0;
   logic [31:0] sample_time = 32'd0;

   function automatic longint clamp_s32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Works out the drive for one request and advances the shadow state exactly as the block
   // should. All intermediate values are held in 64 bits, which the ranges allow throughout.
   function automatic drive_result_type compute_drive(input logic signed [31:0] meas,
                                                      input logic [31:0] now);
      logic [31:0] gap_ms;
      longint unsigned ms, dt, emag, lo, hi, hprod, inc, smag, kmag, sh, sl, hk, mag;
      longint m, tgt, integ, err, derr, acc, fp, fi, fd, q, sum, scale, drv;
      logic neg;
      drive_result_type r;
      // Elapsed time wraps modulo 2^32; a stored stamp of zero means there was no earlier
      // sample, so no time is taken to have passed.
      gap_ms = now - prev_time_ms;
      ms = (prev_time_ms == 32'd0) ? 64'd0 : {32'd0, gap_ms};
      dt = (ms * 64'd65536) / 64'd1000;
      prev_time_ms = now;

      m = meas;
      tgt = set_target;
      err = clamp_s32(tgt - m);
      derr = err - longint'(prev_error);

      // The integral step is formed in two halves of dt so that it stays exact; a high half
      // that is already large enough is known to push the sum past the clamp.
      emag = (err < 0) ? -err : err;
      lo = dt & 64'hFFFF_FFFF;
      hi = dt >> 32;
      hprod = emag * hi;
      integ = integ_q;
      if (hprod >= 64'd65536) begin
         acc = (err < 0) ? -INTEG_CLAMP : INTEG_CLAMP;
      end else begin
         inc = ((emag * lo) >> 16) + (hprod << 16);
         if (err < 0) acc = integ - longint'(inc);
         else acc = integ + longint'(inc);
         if (acc > INTEG_CLAMP) acc = INTEG_CLAMP;
         if (acc < -INTEG_CLAMP) acc = -INTEG_CLAMP;
      end
      integ_q = acc[31:0];
      integ = integ_q;

      // Signed division in SystemVerilog truncates towards zero, as the block rounds.
      fp = (err * longint'(set_gain_p)) / 64'sd65536;
      fi = (integ * longint'(set_gain_i)) / 64'sd65536;
      fd = 0;
      if (dt != 64'd0) begin
         q = (derr * 64'sd65536) / longint'(dt);
         fd = (clamp_s32(q) * longint'(set_gain_d)) / 64'sd65536;
      end
      prev_error = err[31:0];

      // The output scaling is done on magnitudes, split so that the product cannot overflow.
      sum = fp + fi + fd;
      scale = set_scale;
      neg = (sum < 0) != (scale < 0);
      smag = (sum < 0) ? -sum : sum;
      kmag = (scale < 0) ? -scale : scale;
      sh = smag >> 24;
      sl = smag & 64'hFF_FFFF;
      hk = sh * kmag;
      if (hk >= (64'd1 << 39)) mag = 64'd1 << 40;
      else mag = (hk << 8) + ((sl * kmag) >> 16);

      r.saturated = 1'b0;
      if (neg) begin
         if (mag > 64'd2147483648) begin
            drv = -64'sd2147483648;
            r.saturated = 1'b1;
         end else begin
            drv = -longint'(mag);
         end
      end else begin
         if (mag > 64'd2147483647) begin
            drv = 64'sd2147483647;
            r.saturated = 1'b1;
         end else begin
            drv = longint'(mag);
         end
      end
      r.drive = drv[31:0];
      return r;
   endfunction

   // Most gaps are short, but about a quarter are long enough to land on any step of the
   // block's sequence.
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 60);
      return $urandom_range(1, 4);
   endfunction

   // Offers one request and returns at the rising edge at which it is accepted. The valid is
   // left high, so that a request which follows at once is not preceded by a glitch.
   // Ready is sampled at the falling edge, where nothing is changing.
   task automatic send_request(input logic [31:0] meas, input logic [31:0] now);
      req_tvalid <= 1'b1;
      req_tdata <= {now, meas};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      expected_drives.push_back(compute_drive(meas, now));
      @(posedge clock);
   endtask

   task automatic sender_gap();
      if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
   endtask

   // The sender stops and waits until every predicted result has been delivered.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // The write enable is left high here; the caller lowers it once the whole group is done.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CFG_TARGET:       set_target = value;
         CFG_GAIN_P:       set_gain_p = value;
         CFG_GAIN_I:       set_gain_i = value;
         CFG_GAIN_D:       set_gain_d = value;
         CFG_OUTPUT_SCALE: set_scale = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Writes every register while the block is idle. The indexes past the last register are
   // written with random data too; the block must ignore them.
   task automatic configure(input logic [31:0] target, input logic [31:0] gp,
                            input logic [31:0] gi, input logic [31:0] gd,
                            input logic [31:0] scale);
      wait_results_drained();
      write_register(CFG_TARGET, target);
      write_register(CFG_GAIN_P, gp);
      write_register(CFG_GAIN_I, gi);
      write_register(CFG_GAIN_D, gd);
      write_register(CFG_OUTPUT_SCALE, scale);
      for (int k = int'(CFG_OUTPUT_SCALE) + 1; k < (1 << CSR_INDEX_W); k++) begin
         write_register(k[CSR_INDEX_W-1:0], $urandom());
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Settings are mostly moderate, within plus or minus 4.0, with the extremes and fully
   // random words mixed in.
   function automatic logic [31:0] pick_setting();
      case ($urandom_range(0, 9))
         0: return S32_MAX;
         1: return S32_MIN;
         2, 3: return $urandom();
         default: return 32'($urandom_range(0, 524288)) - 32'd262144;
      endcase
   endfunction

   // Mostly a steadily advancing clock with values near the setpoint, as a real loop sees;
   // the rest are equal stamps, zero stamps, jumps anywhere and wild measurements.
   task automatic random_sample(output logic [31:0] meas, output logic [31:0] now);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      meas = set_target + 32'($urandom_range(0, 2097152)) - 32'd1048576;
      if (pick < 70) now = sample_time + 32'($urandom_range(1, 1500));
      else if (pick < 75) now = sample_time + 32'($urandom_range(1, 1048576));
      else if (pick < 82) now = sample_time;
      else if (pick < 86) now = 32'd0;
      else if (pick < 92) now = $urandom();
      else begin
         now = sample_time + 32'($urandom_range(1, 1500));
         meas = $urandom();
      end
      if ($urandom_range(0, 99) < 10) meas = $urandom();
      sample_time = now;
   endtask

   // With the reset settings every gain is zero, so every drive must be zero.
   task automatic test_reset_defaults();
      send_request(32'h1234_5678, 32'd10);
      send_request(S32_MIN, 32'd20);
      send_request(S32_MAX, 32'd0);
   endtask

   task automatic test_special_cases();
      configure(32'sd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
      // A zero timestamp leaves the stored stamp at zero, so the next sample has no elapsed
      // time either.
      send_request(32'sd0, 32'd0);
      send_request(S32_MAX, 32'd1000);
      // Equal stamps give no elapsed time; the error here lies beyond the 32-bit range.
      send_request(S32_MIN, 32'd1000);
      send_request(S32_MIN, 32'd1001);
      // A full-scale swing of the error over one millisecond overflows the derivative.
      send_request(S32_MAX, 32'd1002);
      // Almost a whole wrap of the clock with a large error must clamp the integral.
      send_request(S32_MAX, 32'hFFFF_FFFF);
      send_request(32'sd0, 32'h8000_0000);
      send_request(-Q_ONE, 32'h8000_0003);
      send_request(32'sd0, 32'd0);
      send_request(Q_ONE, 32'd500);

      // Every setting at its maximum drives the output into saturation.
      configure(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
      send_request(S32_MIN, 32'd5000);
      send_request(S32_MAX, 32'd5001);
      send_request(32'sd0, 32'd9000);

      configure(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
      send_request(S32_MAX, 32'd9100);
      send_request(S32_MIN, 32'd9101);
      send_request(32'sd0, 32'hFFFF_FFF0);

      // A negative error with positive gains saturates towards the most negative drive.
      configure(S32_MIN, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
      send_request(S32_MAX, 32'd12);
      send_request(32'sd0, 32'd40);

      // A zero output scale suppresses the drive whatever the terms are.
      configure(S32_MAX, S32_MAX, S32_MIN, S32_MAX, 32'sd0);
      send_request(S32_MIN, 32'd41);
      send_request(Q_ONE, 32'd3000);
   endtask

   task automatic test_random_phases();
      logic [31:0] meas, now;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                   pick_setting());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sender_gap();
            random_sample(meas, now);
            send_request(meas, now);
         end
      end
   endtask

   // A long stretch in which neither side ever idles.
   task automatic test_full_rate();
      logic [31:0] meas, now;
      no_idle = 1'b1;
      configure(32'(Q_ONE * 5), 32'(Q_ONE * 2), Q_ONE >>> 1, Q_ONE >>> 2, Q_ONE);
      for (int n = 0; n < FULL_RATE_ITEMS; n++) begin
         random_sample(meas, now);
         send_request(meas, now);
      end
      wait_results_drained();
      no_idle = 1'b0;
   endtask

   // The receiver holds off for a long while as requests keep coming, so that the output
   // register fills and the block stops accepting. Afterwards the sender pauses until all
   // results are in, and then sends another burst.
   task automatic test_backpressure();
      logic [31:0] meas, now;
      configure(pick_setting(), Q_ONE, Q_ONE, Q_ONE, Q_ONE);
      hold_requests = hold_requests + 1;
      for (int n = 0; n < BURST_ITEMS; n++) begin
         random_sample(meas, now);
         send_request(meas, now);
      end
      wait_results_drained();
      repeat (20) @(posedge clock);
      for (int n = 0; n < BURST_ITEMS; n++) begin
         random_sample(meas, now);
         send_request(meas, now);
      end
   endtask

   // Receiver side: a long hold-off when one is asked for, random single-cycle stalls
   // otherwise.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_tready <= 1'b0;
         stall_left <= LONG_HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each result is checked at the falling edge before the rising edge that takes it.
   always @(negedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drives.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual drive %h saturated %b",
                     $time, rsp_tdata, rsp_tuser[0]);
            error_count = error_count + 1;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_tdata !== want.drive) begin
               $display("%0t: drive mismatch, expected %h, actual %h",
                        $time, want.drive, rsp_tdata);
               error_count = error_count + 1;
            end
            if (rsp_tuser[0] !== want.saturated) begin
               $display("%0t: saturated mismatch, expected %b, actual %b",
                        $time, want.saturated, rsp_tuser[0]);
               error_count = error_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_drives.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_special_cases();
      test_full_rate();
      test_backpressure();
      test_random_phases();
      wait_results_drained();
      // Any result that turns up now has no request behind it.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
